FILE: rtl/lpks_pkg.sv
// Package for the linear probing key set: payload types, request codes,
// field widths, the mixing constant and the probe engine state type.
// No dependencies.
package lpks_pkg;

   localparam int SLOTS_LOG2_DEFAULT = 10;
   localparam int QUEUE_DEPTH = 2;

   localparam int KEY_W = 64;
   localparam int REQ_TYPE_W = 2;
   localparam int SALT_W = 10;
   localparam int SLOT_W = 10;
   localparam int COUNT_W = 10;

   localparam logic [KEY_W-1:0] MIX_CONST = 64'h517cc1b727220a95;

   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [KEY_W-1:0] lookup_key;
   } req_payload_type;

   typedef struct packed {
      logic found;
      logic [SLOT_W-1:0] slot_index;
      logic table_full;
      logic [COUNT_W-1:0] entry_count;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PROBE,
      ST_RESP
   } back_state_type;

endpackage

FILE: rtl/lpks_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module lpks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lpks_queue.sv
// Short first-in first-out queue between the hashing front end and the
// probe engine. No dependencies.
module lpks_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input logic clock,
   input logic reset,
   input logic push_valid,
   output logic push_ready,
   input logic [WIDTH-1:0] push_data,
   output logic pop_valid,
   input logic pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign pop_valid = (cnt_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/lpks_front.sv
// Front end: accepts request items, holds the salt register and computes the
// home slot of each key. Depends on lpks_pkg.
module lpks_front #(
   parameter int SLOTS_LOG2 = lpks_pkg::SLOTS_LOG2_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input lpks_pkg::req_payload_type req_payload,
   input logic csr_wr_en,
   input logic [lpks_pkg::SALT_W-1:0] csr_wr_data,
   output logic push_valid,
   input logic push_ready,
   output logic [$bits(lpks_pkg::req_payload_type)+SLOTS_LOG2-1:0] push_data
);
   import lpks_pkg::*;

   localparam logic [SLOTS_LOG2-1:0] MIX_MASKED = MIX_CONST[SLOTS_LOG2-1:0];

   logic [SALT_W-1:0] salt_ff;
   logic stage_valid_ff, stage_valid_in;
   req_payload_type stage_req_ff;
   logic [SLOTS_LOG2-1:0] stage_fold_ff, fold_in;
   logic [SLOTS_LOG2-1:0] home;

   assign fold_in = req_payload.lookup_key[32 +: SLOTS_LOG2]
                  ^ req_payload.lookup_key[SLOTS_LOG2-1:0]
                  ^ SLOTS_LOG2'(salt_ff);
   assign home = stage_fold_ff * MIX_MASKED;

   assign req_ready = !stage_valid_ff || push_ready;
   assign push_valid = stage_valid_ff;
   assign push_data = {stage_req_ff, home};

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_ready) begin
         stage_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         salt_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_wr_en) begin
            salt_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_req_ff <= req_payload;
         stage_fold_ff <= fold_in;
      end
   end

endmodule

FILE: rtl/lpks_back.sv
// Back end: probe engine that walks the slot table, inserts keys, clears the
// table by sweeping it and holds the result register. Depends on lpks_pkg.
module lpks_back #(
   parameter int SLOTS_LOG2 = lpks_pkg::SLOTS_LOG2_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic pop_valid,
   output logic pop_ready,
   input logic [$bits(lpks_pkg::req_payload_type)+SLOTS_LOG2-1:0] pop_data,
   output logic ram_wr_en,
   output logic [SLOTS_LOG2-1:0] ram_wr_addr,
   output logic [lpks_pkg::KEY_W:0] ram_wr_data,
   output logic [SLOTS_LOG2-1:0] ram_rd_addr,
   input logic [lpks_pkg::KEY_W:0] ram_rd_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output lpks_pkg::rsp_payload_type rsp_payload
);
   import lpks_pkg::*;

   localparam int ENTRY_W = $bits(req_payload_type) + SLOTS_LOG2;

   back_state_type state_ff, state_in;
   logic [SLOTS_LOG2-1:0] addr_ff, addr_in;
   logic [SLOTS_LOG2-1:0] chk_ff, chk_in;
   logic [SLOTS_LOG2-1:0] count_ff, count_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic ins_ff, ins_in;
   logic sweep_pending_ff, sweep_pending_in;
   rsp_payload_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   req_payload_type head_req;
   logic [SLOTS_LOG2-1:0] head_home;
   logic slot_free, slot_hit, rsp_free;

   assign head_req = pop_data[ENTRY_W-1:SLOTS_LOG2];
   assign head_home = pop_data[SLOTS_LOG2-1:0];
   assign slot_free = !ram_rd_data[KEY_W];
   assign slot_hit = ram_rd_data[KEY_W] && (ram_rd_data[KEY_W-1:0] == key_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = (head_req.req_type == REQ_CLEAR) ? ST_RESP : ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (slot_free || slot_hit) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = sweep_pending_ff ? ST_SWEEP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = '0;
      ram_rd_addr = addr_ff;
      addr_in = addr_ff;
      chk_in = chk_ff;
      count_in = count_ff;
      key_in = key_ff;
      ins_in = ins_ff;
      sweep_pending_in = sweep_pending_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_SWEEP: begin
            ram_wr_en = 1'b1;
            addr_in = addr_ff + 1'b1;
         end
         ST_IDLE: begin
            pop_ready = 1'b1;
            ram_rd_addr = head_home;
            if (pop_valid) begin
               key_in = head_req.lookup_key;
               ins_in = (head_req.req_type == REQ_INSERT);
               chk_in = head_home;
               addr_in = head_home + 1'b1;
               if (head_req.req_type == REQ_CLEAR) begin
                  addr_in = '0;
                  count_in = '0;
                  sweep_pending_in = 1'b1;
                  res_in = '0;
               end
            end
         end
         ST_PROBE: begin
            chk_in = addr_ff;
            addr_in = addr_ff + 1'b1;
            res_in.found = slot_hit;
            res_in.slot_index = SLOT_W'(chk_ff);
            res_in.table_full = 1'b0;
            res_in.entry_count = COUNT_W'(count_ff);
            if (!slot_hit && slot_free && ins_ff) begin
               if (count_ff[SLOTS_LOG2-1]) begin
                  res_in.table_full = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  ram_wr_addr = chk_ff;
                  ram_wr_data = {1'b1, key_ff};
                  count_in = count_ff + 1'b1;
                  res_in.entry_count = COUNT_W'(count_in);
               end
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               sweep_pending_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         addr_ff <= '0;
         count_ff <= '0;
         sweep_pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         count_ff <= count_in;
         sweep_pending_ff <= sweep_pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff <= chk_in;
      key_ff <= key_in;
      ins_ff <= ins_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/linear_probe_key_set.sv
// Top level of the linear probing key set: front end, queue, probe engine
// and slot table RAM. Depends on lpks_pkg and all lpks_ modules.
//
// Request items (req_) carry a request type and a 64-bit key; each gives
// exactly one result item (rsp_) with the found flag, the slot, the
// table-full flag and the number of stored keys. The salt register is
// written through csr_wr_en and csr_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// An item passes the hashing stage register and the queue, is taken by
// the probe engine in its idle state, probes slots in turn and then
// passes the response state into the result register. The probe engine
// reads one slot per cycle from a single-port-read table RAM, and takes a
// new item only once the last one has reached the result register. A
// clear sweeps the occupancy bits of all 2**SLOTS_LOG2 slots. After reset
// the same sweep runs before the first item is processed; items are still
// accepted into the queue meanwhile. When the receiver stalls, the result
// register holds its item and the engine and queue fill up before
// req_ready falls.
module linear_probe_key_set #(
   parameter int SLOTS_LOG2 = lpks_pkg::SLOTS_LOG2_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input lpks_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input logic rsp_ready,
   output lpks_pkg::rsp_payload_type rsp_payload,
   input logic csr_wr_en,
   input logic [lpks_pkg::SALT_W-1:0] csr_wr_data
);
   import lpks_pkg::*;

   localparam int ENTRY_W = $bits(req_payload_type) + SLOTS_LOG2;
   localparam int SLOT_COUNT = 1 << SLOTS_LOG2;

   logic push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;
   logic ram_wr_en;
   logic [SLOTS_LOG2-1:0] ram_wr_addr, ram_rd_addr;
   logic [KEY_W:0] ram_wr_data, ram_rd_data;

   lpks_front #(
      .SLOTS_LOG2(SLOTS_LOG2)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data)
   );

   lpks_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data)
   );

   lpks_back #(
      .SLOTS_LOG2(SLOTS_LOG2)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data),
      .ram_wr_en(ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   lpks_ram #(
      .WIDTH(KEY_W + 1),
      .DEPTH(SLOT_COUNT)
   ) u_table (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule
